>>> rtl/itt_pkg.sv
// Shared types and constants for the interval min/max/total tracker.
// Used by itt_diff, itt_stats and interval_min_max_total_tracker.
// No dependencies.
package itt_pkg;

    // Width of the saturating total-seconds accumulator.
    localparam int TOTAL_SEC_BITS = 48;

    // Increment width: 32-bit interval seconds plus up to two carried seconds.
    localparam int ADD_W = 34;

    // Working width of the seconds sum, one bit above the wider operand.
    localparam int SUM_W = ((TOTAL_SEC_BITS > ADD_W) ? TOTAL_SEC_BITS : ADD_W) + 1;

    // Nanosecond arithmetic is done on 31 bits so that a sum of two 30-bit
    // values and twice the seconds unit both fit.
    localparam logic [30:0] NS_PER_SEC     = 31'd1000000000;
    localparam logic [30:0] TWO_NS_PER_SEC = 31'd2000000000;

    // Reset value of the limit registers and of the cleared minimum.
    localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SEC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_NSEC = 1'b1;

    // Largest interval that is still counted.
    typedef struct packed {
        logic [31:0] sec;
        logic [31:0] nsec;
    } limit_t;

    // Difference stage result handed to the statistics stage.
    typedef struct packed {
        logic               first;
        logic               used;
        logic signed [32:0] sec;
        logic [29:0]        nsec;
    } diff_t;

endpackage

>>> rtl/itt_diff.sv
// Input register and interval difference stage of the tracker.
// Forms end minus start with nanosecond borrow and checks it against the limit.
// Depends on itt_pkg.
module itt_diff (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           first_sample,
    input  logic [31:0]    start_sec,
    input  logic [29:0]    start_nsec,
    input  logic [31:0]    end_sec,
    input  logic [29:0]    end_nsec,
    input  itt_pkg::limit_t limit,
    output logic           d_valid,
    input  logic           d_stall,
    output itt_pkg::diff_t d_item
);
    import itt_pkg::*;

    logic        s0_valid_reg;
    logic        s0_first_reg;
    logic [31:0] s0_start_sec_reg;
    logic [29:0] s0_start_nsec_reg;
    logic [31:0] s0_end_sec_reg;
    logic [29:0] s0_end_nsec_reg;
    logic        d_valid_reg;
    diff_t       d_item_reg;
    diff_t       d_item_next;

    logic               s0_free;
    logic               s1_free;
    logic signed [32:0] sec_raw;
    logic signed [30:0] ns_raw;
    logic               borrow;
    logic signed [32:0] dsec;
    logic signed [30:0] dnsec;
    logic               non_negative;
    logic               within_limit;

    // A stage may load when it is empty or its item moves on this cycle.
    assign s1_free  = !d_valid_reg || !d_stall;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign in_stall = !s0_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_free)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_free)
        begin
            s0_first_reg      <= first_sample;
            s0_start_sec_reg  <= start_sec;
            s0_start_nsec_reg <= start_nsec;
            s0_end_sec_reg    <= end_sec;
            s0_end_nsec_reg   <= end_nsec;
        end
    end

    // Difference with one borrowed second when the nanoseconds go negative.
    always_comb
    begin
        sec_raw = $signed({1'b0, s0_end_sec_reg}) - $signed({1'b0, s0_start_sec_reg});
        ns_raw  = $signed({1'b0, s0_end_nsec_reg}) - $signed({1'b0, s0_start_nsec_reg});
        borrow  = ns_raw[30];
        dsec    = sec_raw - $signed({32'd0, borrow});
        dnsec   = borrow ? (ns_raw + $signed(NS_PER_SEC)) : ns_raw;
    end

    // Accept only non-negative intervals no larger than the limit.
    always_comb
    begin
        non_negative = !dsec[32] && !dnsec[30];
        within_limit = (dsec[31:0] < limit.sec) ||
                       ((dsec[31:0] == limit.sec) && ({2'b00, dnsec[29:0]} <= limit.nsec));
        d_item_next.first = s0_first_reg;
        d_item_next.used  = non_negative && within_limit;
        d_item_next.sec   = dsec;
        d_item_next.nsec  = dnsec[29:0];
    end

    // Difference register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            d_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && s1_free)
        begin
            d_item_reg <= d_item_next;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_item  = d_item_reg;

endmodule

>>> rtl/itt_stats.sv
// Statistics stage of the tracker: total, minimum and maximum registers
// and the result register. Depends on itt_pkg.
module itt_stats (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 d_valid,
    output logic                                 d_stall,
    input  itt_pkg::diff_t                       d_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 sample_used,
    output logic signed [32:0]                   interval_sec,
    output logic [29:0]                          interval_nsec,
    output logic [itt_pkg::TOTAL_SEC_BITS-1:0]   sum_sec,
    output logic [29:0]                          sum_nsec,
    output logic [31:0]                          least_sec,
    output logic [31:0]                          least_nsec,
    output logic [31:0]                          most_sec,
    output logic [29:0]                          most_nsec
);
    import itt_pkg::*;

    // Running statistics.
    logic [TOTAL_SEC_BITS-1:0] total_sec_reg, total_sec_next;
    logic [29:0]               total_nsec_reg, total_nsec_next;
    logic [31:0]               min_sec_reg, min_sec_next;
    logic [31:0]               min_nsec_reg, min_nsec_next;
    logic [31:0]               max_sec_reg, max_sec_next;
    logic [29:0]               max_nsec_reg, max_nsec_next;

    // Result register.
    logic                      out_valid_reg;
    logic                      sample_used_reg;
    logic signed [32:0]        interval_sec_reg;
    logic [29:0]               interval_nsec_reg;

    logic                      d_accept;
    logic [31:0]               usec;
    logic [29:0]               unsec;
    logic [30:0]               ns_sum;
    logic [30:0]               ns_fold;
    logic [1:0]                carry;
    logic [ADD_W-1:0]          add_sec;
    logic [SUM_W-1:0]          sec_sum;
    logic                      new_min;
    logic                      new_max;

    assign d_stall  = out_valid_reg && out_stall;
    assign d_accept = d_valid && !d_stall;
    assign usec     = d_item.sec[31:0];
    assign unsec    = d_item.nsec;

    // Nanosecond carry: folding once or twice depends only on the raw sum.
    always_comb
    begin
        ns_sum = {1'b0, total_nsec_reg} + {1'b0, unsec};
        if (ns_sum >= TWO_NS_PER_SEC)
        begin
            ns_fold = ns_sum - TWO_NS_PER_SEC;
            carry   = 2'd2;
        end
        else if (ns_sum >= NS_PER_SEC)
        begin
            ns_fold = ns_sum - NS_PER_SEC;
            carry   = 2'd1;
        end
        else
        begin
            ns_fold = ns_sum;
            carry   = 2'd0;
        end
        add_sec = ADD_W'(usec) + ADD_W'(carry);
        sec_sum = SUM_W'(total_sec_reg) + SUM_W'(add_sec);
    end

    // Second-then-nanosecond comparisons for the extremes.
    always_comb
    begin
        new_min = (min_sec_reg > usec) ||
                  ((min_sec_reg == usec) && (min_nsec_reg > {2'b00, unsec}));
        new_max = (max_sec_reg < usec) ||
                  ((max_sec_reg == usec) && (max_nsec_reg < unsec));
    end

    // Next statistics: clear on a first sample, then take a used interval.
    always_comb
    begin
        total_sec_next  = total_sec_reg;
        total_nsec_next = total_nsec_reg;
        min_sec_next    = min_sec_reg;
        min_nsec_next   = min_nsec_reg;
        max_sec_next    = max_sec_reg;
        max_nsec_next   = max_nsec_reg;
        if (d_item.first)
        begin
            if (d_item.used)
            begin
                total_sec_next  = TOTAL_SEC_BITS'(usec);
                total_nsec_next = unsec;
                min_sec_next    = usec;
                min_nsec_next   = {2'b00, unsec};
                max_sec_next    = usec;
                max_nsec_next   = unsec;
            end
            else
            begin
                total_sec_next  = '0;
                total_nsec_next = '0;
                min_sec_next    = ALL_ONES_32;
                min_nsec_next   = ALL_ONES_32;
                max_sec_next    = '0;
                max_nsec_next   = '0;
            end
        end
        else if (d_item.used)
        begin
            total_nsec_next = ns_fold[29:0];
            if (|sec_sum[SUM_W-1:TOTAL_SEC_BITS])
            begin
                total_sec_next = '1;
            end
            else
            begin
                total_sec_next = sec_sum[TOTAL_SEC_BITS-1:0];
            end
            if (new_min)
            begin
                min_sec_next  = usec;
                min_nsec_next = {2'b00, unsec};
            end
            if (new_max)
            begin
                max_sec_next  = usec;
                max_nsec_next = unsec;
            end
        end
    end

    // Statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_sec_reg  <= '0;
            total_nsec_reg <= '0;
            min_sec_reg    <= ALL_ONES_32;
            min_nsec_reg   <= ALL_ONES_32;
            max_sec_reg    <= '0;
            max_nsec_reg   <= '0;
        end
        else if (d_accept)
        begin
            total_sec_reg  <= total_sec_next;
            total_nsec_reg <= total_nsec_next;
            min_sec_reg    <= min_sec_next;
            min_nsec_reg   <= min_nsec_next;
            max_sec_reg    <= max_sec_next;
            max_nsec_reg   <= max_nsec_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (d_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Per-item result fields.
    always_ff @(posedge clk)
    begin
        if (d_accept)
        begin
            sample_used_reg   <= d_item.used;
            interval_sec_reg  <= d_item.sec;
            interval_nsec_reg <= d_item.nsec;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_used   = sample_used_reg;
    assign interval_sec  = interval_sec_reg;
    assign interval_nsec = interval_nsec_reg;
    assign sum_sec       = total_sec_reg;
    assign sum_nsec      = total_nsec_reg;
    assign least_sec     = min_sec_reg;
    assign least_nsec    = min_nsec_reg;
    assign most_sec      = max_sec_reg;
    assign most_nsec     = max_nsec_reg;

    // After a used interval the minimum never lies above the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sample_used_reg) |->
        ((min_sec_reg < max_sec_reg) ||
         ((min_sec_reg == max_sec_reg) && (min_nsec_reg <= {2'b00, max_nsec_reg}))))
        else $error("minimum above maximum after a used interval");

    // An ignored item that is not a first sample leaves the statistics alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_accept && !d_item.used && !d_item.first) |=>
        (total_sec_reg == $past(total_sec_reg) && min_sec_reg == $past(min_sec_reg) &&
         max_sec_reg == $past(max_sec_reg)))
        else $error("statistics changed on an ignored item");

    // An ignored first sample leaves the statistics cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_accept && !d_item.used && d_item.first) |=>
        (total_sec_reg == '0 && min_sec_reg == ALL_ONES_32 && max_sec_reg == '0))
        else $error("statistics not cleared on an ignored first sample");

    // Outside a first sample the seconds total never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_accept && !d_item.first) |=> (total_sec_reg >= $past(total_sec_reg)))
        else $error("seconds total decreased");

endmodule

>>> rtl/interval_min_max_total_tracker.sv
// Top level of the interval min/max/total tracker: limit registers and the
// difference and statistics stages. Depends on itt_pkg, itt_diff and itt_stats.
//
// The tracker takes one start/end timestamp pair per clock while in_stall is
// low and returns one item per input item, in order, with the interval,
// whether it was counted, and the total, minimum and maximum after the
// update. An accepted item passes three register stages in order (input,
// difference, result). Sustained rate is one item per clock while out_stall
// is low, set by the statistics registers, whose update loop (nanosecond
// fold, saturating seconds add, extreme compares) is closed combinationally.
// Write the limit registers only while no item is in flight.
module interval_min_max_total_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [itt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 first_sample,
    input  logic [31:0]                          start_sec,
    input  logic [29:0]                          start_nsec,
    input  logic [31:0]                          end_sec,
    input  logic [29:0]                          end_nsec,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 sample_used,
    output logic signed [32:0]                   interval_sec,
    output logic [29:0]                          interval_nsec,
    output logic [itt_pkg::TOTAL_SEC_BITS-1:0]   sum_sec,
    output logic [29:0]                          sum_nsec,
    output logic [31:0]                          least_sec,
    output logic [31:0]                          least_nsec,
    output logic [31:0]                          most_sec,
    output logic [29:0]                          most_nsec
);
    import itt_pkg::*;

    limit_t limit_reg;
    logic   d_valid;
    logic   d_stall;
    diff_t  d_item;

    // Limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg.sec  <= ALL_ONES_32;
            limit_reg.nsec <= ALL_ONES_32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIMIT_SEC:  limit_reg.sec  <= cfg_data;
                CFG_LIMIT_NSEC: limit_reg.nsec <= cfg_data;
                default:        limit_reg      <= limit_reg;
            endcase
        end
    end

    // Input register and difference stage.
    itt_diff u_diff (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_sample (first_sample),
        .start_sec    (start_sec),
        .start_nsec   (start_nsec),
        .end_sec      (end_sec),
        .end_nsec     (end_nsec),
        .limit        (limit_reg),
        .d_valid      (d_valid),
        .d_stall      (d_stall),
        .d_item       (d_item)
    );

    // Statistics update and result register.
    itt_stats u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .d_valid       (d_valid),
        .d_stall       (d_stall),
        .d_item        (d_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_used   (sample_used),
        .interval_sec  (interval_sec),
        .interval_nsec (interval_nsec),
        .sum_sec       (sum_sec),
        .sum_nsec      (sum_nsec),
        .least_sec     (least_sec),
        .least_nsec    (least_nsec),
        .most_sec      (most_sec),
        .most_nsec     (most_nsec)
    );

endmodule

>>> test/tb_interval_min_max_total_tracker.sv
// Testbench for interval_min_max_total_tracker: drives timestamp pairs, predicts the
// interval, total, minimum and maximum in-line and checks every result item.
// Depends on itt_pkg and the tracker RTL only.
module tb_interval_min_max_total_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import itt_pkg::*;

    localparam longint      NANOS       = 1000000000;
    localparam logic [63:0] SEC_MAX     = (64'd1 << TOTAL_SEC_BITS) - 64'd1;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned PRINT_CAP   = 100;

    // One timestamp pair as presented on the input channel.
    typedef struct {
        logic        first;
        logic [31:0] start_sec;
        logic [29:0] start_ns;
        logic [31:0] end_sec;
        logic [29:0] end_ns;
    } pair_t;

    // One result item as seen on the output channel.
    typedef struct {
        logic                      used;
        logic [32:0]               ivl_sec;
        logic [29:0]               ivl_ns;
        logic [TOTAL_SEC_BITS-1:0] sum_sec;
        logic [29:0]               sum_ns;
        logic [31:0]               least_sec;
        logic [31:0]               least_ns;
        logic [31:0]               most_sec;
        logic [29:0]               most_ns;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LIMIT_SEC;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic first_sample = 1'b0;
    logic [31:0] start_sec = '0;
    logic [29:0] start_nsec = '0;
    logic [31:0] end_sec = '0;
    logic [29:0] end_nsec = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic sample_used;
    logic signed [32:0] interval_sec;
    logic [29:0] interval_nsec;
    logic [TOTAL_SEC_BITS-1:0] sum_sec;
    logic [29:0] sum_nsec;
    logic [31:0] least_sec;
    logic [31:0] least_nsec;
    logic [31:0] most_sec;
    logic [29:0] most_nsec;

    // Limit registers as last written, and the tracked statistics.
    logic [31:0] lim_sec = 32'hFFFF_FFFF;
    logic [31:0] lim_ns = 32'hFFFF_FFFF;
    logic [63:0] tot_sec = '0;
    logic [63:0] tot_ns = '0;
    logic [63:0] lo_sec = 64'hFFFF_FFFF;
    logic [63:0] lo_ns = 64'hFFFF_FFFF;
    logic [63:0] hi_sec = '0;
    logic [63:0] hi_ns = '0;

    pair_t  pending_pairs[$];
    stats_t stats_due[$];
    pair_t  on_wire;

    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    logic rush = 1'b0;
    logic calm_send = 1'b0;
    logic calm_recv = 1'b0;

    interval_min_max_total_tracker dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .first_sample(first_sample),
        .start_sec(start_sec),
        .start_nsec(start_nsec),
        .end_sec(end_sec),
        .end_nsec(end_nsec),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_used(sample_used),
        .interval_sec(interval_sec),
        .interval_nsec(interval_nsec),
        .sum_sec(sum_sec),
        .sum_nsec(sum_nsec),
        .least_sec(least_sec),
        .least_nsec(least_nsec),
        .most_sec(most_sec),
        .most_nsec(most_nsec)
    );

    always #5 clk = ~clk;

    // Clears total, minimum and maximum as a first sample does.
    function automatic void clear_stats();
        tot_sec = '0;
        tot_ns = '0;
        lo_sec = 64'hFFFF_FFFF;
        lo_ns = 64'hFFFF_FFFF;
        hi_sec = '0;
        hi_ns = '0;
    endfunction

    // Forms end minus start, applies the limit and updates the statistics.
    function automatic stats_t track_interval(pair_t p);
        longint      dsec;
        longint      dns;
        logic [63:0] us;
        logic [63:0] uns;
        logic [63:0] ns_sum;
        logic [63:0] add_sec;
        logic        take;
        stats_t      r;
        dsec = longint'({32'b0, p.end_sec}) - longint'({32'b0, p.start_sec});
        dns = longint'({34'b0, p.end_ns}) - longint'({34'b0, p.start_ns});
        if (dns < 0) begin
            dsec = dsec - 1;
            dns = dns + NANOS;
        end
        if (p.first)
            clear_stats();
        us = dsec;
        uns = dns;
        take = 1'b0;
        if (dsec >= 0 && dns >= 0)
            take = (us < lim_sec) || (us == lim_sec && uns <= lim_ns);

        if (take && p.first) begin
            tot_sec = us & SEC_MAX;
            tot_ns = uns;
            lo_sec = us;
            lo_ns = uns;
            hi_sec = us;
            hi_ns = uns;
        end else if (take) begin
            // Nanosecond carry folds at most twice, then seconds saturate.
            ns_sum = tot_ns + uns;
            add_sec = us;
            repeat (2) begin
                if (ns_sum >= NANOS) begin
                    ns_sum = ns_sum - NANOS;
                    add_sec = add_sec + 1;
                end
            end
            tot_ns = {34'b0, ns_sum[29:0]};
            if (add_sec > SEC_MAX || tot_sec > SEC_MAX - add_sec)
                tot_sec = SEC_MAX;
            else
                tot_sec = tot_sec + add_sec;
            if (lo_sec > us || (lo_sec == us && lo_ns > uns)) begin
                lo_sec = us;
                lo_ns = uns;
            end
            if (hi_sec < us || (hi_sec == us && hi_ns < uns)) begin
                hi_sec = us;
                hi_ns = uns;
            end
        end

        r.used = take;
        r.ivl_sec = us[32:0];
        r.ivl_ns = uns[29:0];
        r.sum_sec = tot_sec[TOTAL_SEC_BITS-1:0];
        r.sum_ns = tot_ns[29:0];
        r.least_sec = lo_sec[31:0];
        r.least_ns = lo_ns[31:0];
        r.most_sec = hi_sec[31:0];
        r.most_ns = hi_ns[29:0];
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                    results_seen, name, got, want));
    endtask

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int unsigned pick_delay(input logic calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || rush)
            return 0;
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic void add_pair(input logic first, input logic [31:0] ss,
                                     input logic [29:0] sn, input logic [31:0] es,
                                     input logic [29:0] en);
        pair_t p;
        p.first = first;
        p.start_sec = ss;
        p.start_ns = sn;
        p.end_sec = es;
        p.end_ns = en;
        pending_pairs.push_back(p);
    endfunction

    // Queues random pairs; most are well-formed intervals, some right at the limit.
    task automatic queue_random(input int count);
        logic        first;
        logic [31:0] span_sec;
        logic [31:0] span_ns;
        logic [31:0] cap_ns;
        logic [31:0] ss;
        logic [31:0] sn;
        logic [31:0] es;
        logic [31:0] en;
        int unsigned k;
        for (int i = 0; i < count; i++) begin
            first = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // Noise: any field value, nanoseconds over their full width.
                add_pair(first, $urandom, 30'($urandom_range(0, 30'h3FFF_FFFF)),
                         $urandom, 30'($urandom_range(0, 30'h3FFF_FFFF)));
            end else begin
                cap_ns = (lim_ns > 999999999) ? 32'd999999999 : lim_ns;
                span_ns = $urandom_range(0, 999999999);
                case ($urandom_range(0, 5))
                    0: span_sec = $urandom_range(0, 3);
                    1: begin
                        span_sec = lim_sec;
                        k = $urandom_range(0, 2);
                        if (k == 0 && cap_ns > 0)
                            span_ns = cap_ns - 1;
                        else if (k == 2 && cap_ns < 999999999)
                            span_ns = cap_ns + 1;
                        else
                            span_ns = cap_ns;
                    end
                    2: span_sec = $urandom_range(0, lim_sec);
                    3: span_sec = $urandom;
                    4: span_sec = 32'hFFFF_FFFF - $urandom_range(0, 2);
                    default: begin
                        span_sec = 0;
                        span_ns = $urandom_range(0, 10);
                    end
                endcase
                ss = $urandom_range(0, 32'hFFFF_FFFF - span_sec);
                sn = $urandom_range(0, 999999999);
                es = ss + span_sec;
                en = sn + span_ns;
                if (en >= 999999999 + 1) begin
                    en = en - 1000000000;
                    es = es + 1;
                end
                if ($urandom_range(0, 9) == 0)
                    add_pair(first, es, en[29:0], ss, sn[29:0]);
                else
                    add_pair(first, ss, sn[29:0], es, en[29:0]);
            end
        end
    endtask

    // Waits until every queued item has been sent and every result has come.
    task automatic drain();
        while (pending_pairs.size() != 0 || in_valid || stats_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LIMIT_SEC: lim_sec = val;
            default: lim_ns = val;
        endcase
    endtask

    // Cycle count, timeout, and toggling of the stretches without idling.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if ($urandom_range(0, 199) == 0)
            calm_send <= ~calm_send;
        if ($urandom_range(0, 199) == 0)
            calm_recv <= ~calm_recv;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Driver: predicts each accepted item and presents the next pending one.
    always @(posedge clk) begin
        if (in_valid && !in_stall)
            stats_due.push_back(track_interval(on_wire));
        if (!rst_n || (in_valid && in_stall)) begin
            // Hold the stalled item unchanged.
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
            on_wire = pending_pairs.pop_front();
            first_sample <= on_wire.first;
            start_sec <= on_wire.start_sec;
            start_nsec <= on_wire.start_ns;
            end_sec <= on_wire.end_sec;
            end_nsec <= on_wire.end_ns;
            in_valid <= 1'b1;
            send_gap = pick_delay(calm_send);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk) begin
        stats_t got;
        stats_t want;
        if (rst_n && out_valid && !out_stall) begin
            got.used = sample_used;
            got.ivl_sec = interval_sec;
            got.ivl_ns = interval_nsec;
            got.sum_sec = sum_sec;
            got.sum_ns = sum_nsec;
            got.least_sec = least_sec;
            got.least_ns = least_nsec;
            got.most_sec = most_sec;
            got.most_ns = most_nsec;
            if (stats_due.size() == 0) begin
                note_mismatch("result item with no prediction pending");
            end else begin
                want = stats_due.pop_front();
                cmp_field("sample_used", got.used, want.used);
                cmp_field("interval_sec", got.ivl_sec, want.ivl_sec);
                cmp_field("interval_nsec", got.ivl_ns, want.ivl_ns);
                cmp_field("sum_sec", got.sum_sec, want.sum_sec);
                cmp_field("sum_nsec", got.sum_ns, want.sum_ns);
                cmp_field("least_sec", got.least_sec, want.least_sec);
                cmp_field("least_nsec", got.least_ns, want.least_ns);
                cmp_field("most_sec", got.most_sec, want.most_sec);
                cmp_field("most_nsec", got.most_ns, want.most_ns);
            end
            results_seen++;
        end
        if (hold_left == 0)
            hold_left = pick_delay(calm_recv);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Stimulus phases, each under its own limit setting.
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limits: extremes, borrows, out-of-range nanoseconds, clearing.
        add_pair(1, 0, 0, 0, 0);
        add_pair(0, 0, 0, 32'hFFFF_FFFF, 999999999);
        add_pair(0, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 0, 0);
        add_pair(0, 5, 900000000, 7, 100000000);
        add_pair(0, 5, 500000000, 5, 400000000);
        add_pair(1, 0, 0, 0, 30'h3FFF_FFFF);
        add_pair(0, 9, 0, 9, 30'h3FFF_FFFF);
        add_pair(0, 3, 30'h3FFF_FFFF, 4, 0);
        add_pair(1, 1, 0, 0, 0);
        add_pair(0, 100, 0, 102, 500000000);
        add_pair(0, 200, 0, 202, 400000000);
        add_pair(0, 300, 0, 302, 600000000);
        add_pair(0, 0, 0, 0, 0);
        add_pair(1, 32'hFFFF_FFFF, 999999999, 32'hFFFF_FFFF, 999999999);
        drain();

        // Limit of 3.25 s: exactly at, just above and below the limit.
        write_limit(CFG_LIMIT_SEC, 3);
        write_limit(CFG_LIMIT_NSEC, 250000000);
        add_pair(1, 10, 0, 13, 250000000);
        add_pair(0, 10, 0, 13, 250000001);
        add_pair(0, 10, 0, 13, 249999999);
        add_pair(0, 10, 0, 14, 0);
        add_pair(0, 10, 500000000, 13, 750000000);
        queue_random(300);
        drain();

        // Zero limit: only an empty interval counts.
        write_limit(CFG_LIMIT_NSEC, 0);
        write_limit(CFG_LIMIT_SEC, 0);
        add_pair(1, 50, 7, 50, 7);
        add_pair(0, 50, 7, 50, 8);
        add_pair(0, 50, 8, 50, 7);
        queue_random(200);
        drain();

        // Nanosecond limit above one second of nanoseconds.
        write_limit(CFG_LIMIT_NSEC, 32'hFFFF_FFFF);
        add_pair(1, 0, 0, 0, 30'h3FFF_FFFF);
        add_pair(0, 0, 0, 1, 0);
        queue_random(200);
        drain();

        write_limit(CFG_LIMIT_SEC, $urandom_range(1, 100000));
        write_limit(CFG_LIMIT_NSEC, $urandom_range(0, 999999999));
        queue_random(500);
        drain();

        write_limit(CFG_LIMIT_SEC, 32'hFFFF_FFFF);
        write_limit(CFG_LIMIT_NSEC, 32'hFFFF_FFFF);
        queue_random(500);
        drain();

        // Longest intervals back to back with no idling on either side.
        rush = 1'b1;
        add_pair(1, 0, 0, 32'hFFFF_FFFF, 999999999);
        for (int i = 0; i < 15; i++)
            add_pair(0, 0, 0, 32'hFFFF_FFFF, 999999999);
        drain();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
